@@ src/data_stack_alu_macros.svh @@
// Assertion macros for the data stack ALU sources.
`ifndef DATA_STACK_ALU_MACROS_SVH
`define DATA_STACK_ALU_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define DSA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication outside reset
`define DSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ src/dsa_pkg.sv @@
// Types and constants of the data stack ALU modules.
`default_nettype none

package dsa_pkg;

  // Fixed port widths of the item fields
  localparam int LIT_W = 32;
  localparam int TOP_W = 32;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_DUP  = 3'd5,
    OP_DROP = 3'd6,
    OP_OVER = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_UNDER   = 2'd1,
    ERR_OVER    = 2'd2,
    ERR_DIVZERO = 2'd3
  } err_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_OPND = 3'd1,
    S_MUL  = 3'd2,
    S_ABSN = 3'd3,
    S_ABST = 3'd4,
    S_DIV  = 3'd5,
    S_FIX  = 3'd6,
    S_RESP = 3'd7
  } state_t;

endpackage

`default_nettype wire

@@ src/dsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/dsa_alu.sv @@
// Shared adder/subtractor with carry out, used for every arithmetic step.
`default_nettype none

module dsa_alu #(
  parameter int WIDTH = 33
) (
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  input  wire logic             sub,
  output logic      [WIDTH:0]   sum
);

  logic [WIDTH-1:0] b_sel;

  // a + b, or a - b as a + ~b + 1; top bit is the carry (a >= b when subtracting)
  always_comb begin
    b_sel = sub ? ~b : b;
    sum   = {1'b0, a} + {1'b0, b_sel} + (WIDTH+1)'(sub);
  end

endmodule

`default_nettype wire

@@ src/data_stack_alu.sv @@
// Forth-style data stack with push, add, sub, mul, div, dup, drop and over.
//
// Usage: an item (in_operation, in_literal) is taken when in_valid is high and
// in_stall is low. Each item gives exactly one result (out_top_value,
// out_stack_depth, out_error_code), offered with out_valid and held while
// out_stall is high. The block takes one item at a time; in_stall stays high
// from acceptance until the result has been loaded into the output register.
// Sequencer states from acceptance to the result (and to in_stall falling):
//   push, dup, drop of the last element, any error : S_RESP
//   add, sub, drop, over : S_OPND (one RAM read of next), S_RESP
//   mul : S_OPND, S_MUL loop, S_FIX, S_RESP
//   div : S_OPND, S_ABSN, S_ABST, S_DIV loop, S_FIX, S_RESP
// mul and div run one bit a cycle through the single shared adder.
// The top element sits in a register; the elements below it live in a RAM
// with one write and one registered read port.
// Reset empties the stack (depth zero) and clears out_valid; the RAM needs
// no clearing pass. While out_stall holds a result, the next item's result
// waits in the sequencer's response state and no new item is taken.
`default_nettype none

module data_stack_alu #(
  parameter int STACK_DEPTH = 64,
  parameter int DATA_WIDTH  = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [2:0]                           in_operation,
  input  wire logic signed [dsa_pkg::LIT_W-1:0]     in_literal,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [dsa_pkg::TOP_W-1:0]          out_top_value,
  output logic [$clog2(STACK_DEPTH+1)-1:0]          out_stack_depth,
  output logic [1:0]                                out_error_code
);

  import dsa_pkg::*;

  `include "data_stack_alu_macros.svh"

  localparam int DEP_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(DATA_WIDTH);
  localparam int UW     = DATA_WIDTH + 1;

  state_t                  state_r, state_nxt;
  op_t                     op_r, op_nxt, op_in;
  err_t                    err_r, err_nxt, err_in;
  logic [DEP_W-1:0]        depth_r, depth_nxt;
  logic [DATA_WIDTH-1:0]   top_r, top_nxt;
  logic [DATA_WIDTH-1:0]   x_r, x_nxt;
  logic [DATA_WIDTH-1:0]   y_r, y_nxt;
  logic [DATA_WIDTH-1:0]   acc_r, acc_nxt;
  logic                    neg_r, neg_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [TOP_W-1:0]        out_top_r, out_top_nxt;
  logic [DEP_W-1:0]        out_depth_r, out_depth_nxt;
  err_t                    out_err_r, out_err_nxt;

  logic                    in_accept;
  logic                    out_free;
  logic                    stack_full;
  logic                    cnt_last;
  logic [DATA_WIDTH-1:0]   lit_w;
  logic [DATA_WIDTH:0]     remsh;
  logic                    div_ge;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [DATA_WIDTH-1:0]   ram_wdata;
  logic [DATA_WIDTH-1:0]   ram_rdata;

  logic [UW-1:0]           alu_a;
  logic [UW-1:0]           alu_b;
  logic                    alu_sub;
  logic [UW:0]             alu_sum;

  // Store for the elements below the top
  dsa_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared arithmetic unit
  dsa_alu #(
    .WIDTH (UW)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  // Handshake and decode of the incoming item
  assign in_stall   = (state_r != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign op_in      = op_t'(in_operation);
  assign lit_w      = DATA_WIDTH'(in_literal);
  assign stack_full = (depth_r == DEP_W'(STACK_DEPTH));
  assign cnt_last   = (cnt_r == CNT_W'(DATA_WIDTH - 1));
  assign remsh      = {acc_r, x_r[DATA_WIDTH-1]};
  assign div_ge     = alu_sum[UW];
  assign ram_raddr  = ADDR_W'(depth_r - DEP_W'(2));

  // Error check: underflow before overflow, then divide by zero
  always_comb begin
    err_in = ERR_OK;
    unique case (op_in)
      OP_PUSH: begin
        if (stack_full) err_in = ERR_OVER;
      end
      OP_ADD, OP_SUB, OP_MUL: begin
        if (depth_r < DEP_W'(2)) err_in = ERR_UNDER;
      end
      OP_DIV: begin
        if (depth_r < DEP_W'(2)) err_in = ERR_UNDER;
        else if (top_r == '0)    err_in = ERR_DIVZERO;
      end
      OP_DUP: begin
        if (depth_r == '0)    err_in = ERR_UNDER;
        else if (stack_full)  err_in = ERR_OVER;
      end
      OP_DROP: begin
        if (depth_r == '0) err_in = ERR_UNDER;
      end
      OP_OVER: begin
        if (depth_r < DEP_W'(2)) err_in = ERR_UNDER;
        else if (stack_full)     err_in = ERR_OVER;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (err_in != ERR_OK) begin
            state_nxt = S_RESP;
          end else begin
            unique case (op_in)
              OP_PUSH, OP_DUP: state_nxt = S_RESP;
              OP_DROP:         state_nxt = (depth_r == DEP_W'(1)) ? S_RESP : S_OPND;
              default:         state_nxt = S_OPND;
            endcase
          end
        end
      end
      S_OPND: begin
        unique case (op_r)
          OP_MUL:  state_nxt = S_MUL;
          OP_DIV:  state_nxt = S_ABSN;
          default: state_nxt = S_RESP;
        endcase
      end
      S_MUL:  state_nxt = cnt_last ? S_FIX : S_MUL;
      S_ABSN: state_nxt = S_ABST;
      S_ABST: state_nxt = S_DIV;
      S_DIV:  state_nxt = cnt_last ? S_FIX : S_DIV;
      S_FIX:  state_nxt = S_RESP;
      S_RESP: state_nxt = out_free ? S_IDLE : S_RESP;
    endcase
  end

  // Datapath control and register updates
  always_comb begin
    op_nxt        = op_r;
    err_nxt       = err_r;
    depth_nxt     = depth_r;
    top_nxt       = top_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    out_top_nxt   = out_top_r;
    out_depth_nxt = out_depth_r;
    out_err_nxt   = out_err_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = ADDR_W'(depth_r - DEP_W'(1));
    ram_wdata     = top_r;
    alu_a         = '0;
    alu_b         = '0;
    alu_sub       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt  = op_in;
          err_nxt = err_in;
          if (err_in == ERR_OK) begin
            unique case (op_in)
              OP_PUSH: begin
                // old top spills to the store
                ram_we    = (depth_r != '0);
                top_nxt   = lit_w;
                depth_nxt = depth_r + DEP_W'(1);
              end
              OP_DUP: begin
                ram_we    = 1'b1;
                depth_nxt = depth_r + DEP_W'(1);
              end
              OP_OVER: begin
                ram_we = 1'b1;
              end
              OP_DROP: begin
                if (depth_r == DEP_W'(1)) depth_nxt = '0;
              end
              default: begin
                ram_we = 1'b0;
              end
            endcase
          end
        end
      end
      S_OPND: begin
        // ram_rdata holds the element below the top
        alu_a = {1'b0, ram_rdata};
        alu_b = {1'b0, top_r};
        unique case (op_r)
          OP_ADD: begin
            top_nxt   = alu_sum[DATA_WIDTH-1:0];
            depth_nxt = depth_r - DEP_W'(1);
          end
          OP_SUB: begin
            alu_sub   = 1'b1;
            top_nxt   = alu_sum[DATA_WIDTH-1:0];
            depth_nxt = depth_r - DEP_W'(1);
          end
          OP_DROP: begin
            top_nxt   = ram_rdata;
            depth_nxt = depth_r - DEP_W'(1);
          end
          OP_OVER: begin
            top_nxt   = ram_rdata;
            depth_nxt = depth_r + DEP_W'(1);
          end
          OP_MUL: begin
            x_nxt   = ram_rdata;
            y_nxt   = top_r;
            acc_nxt = '0;
            cnt_nxt = '0;
          end
          OP_DIV: begin
            x_nxt   = ram_rdata;
            y_nxt   = top_r;
            neg_nxt = ram_rdata[DATA_WIDTH-1] ^ top_r[DATA_WIDTH-1];
          end
          default: begin
            top_nxt = top_r;
          end
        endcase
      end
      S_MUL: begin
        // shift-and-add, one multiplier bit a cycle
        alu_a   = {1'b0, acc_r};
        alu_b   = y_r[0] ? {1'b0, x_r} : '0;
        acc_nxt = alu_sum[DATA_WIDTH-1:0];
        x_nxt   = {x_r[DATA_WIDTH-2:0], 1'b0};
        y_nxt   = {1'b0, y_r[DATA_WIDTH-1:1]};
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      S_ABSN: begin
        alu_b   = {1'b0, x_r};
        alu_sub = 1'b1;
        if (x_r[DATA_WIDTH-1]) x_nxt = alu_sum[DATA_WIDTH-1:0];
      end
      S_ABST: begin
        alu_b   = {1'b0, y_r};
        alu_sub = 1'b1;
        if (y_r[DATA_WIDTH-1]) y_nxt = alu_sum[DATA_WIDTH-1:0];
        acc_nxt = '0;
        cnt_nxt = '0;
      end
      S_DIV: begin
        // restoring division, one quotient bit a cycle
        alu_a   = remsh;
        alu_b   = {1'b0, y_r};
        alu_sub = 1'b1;
        acc_nxt = div_ge ? alu_sum[DATA_WIDTH-1:0] : remsh[DATA_WIDTH-1:0];
        x_nxt   = {x_r[DATA_WIDTH-2:0], div_ge};
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      S_FIX: begin
        alu_b   = {1'b0, x_r};
        alu_sub = 1'b1;
        if (op_r == OP_MUL) top_nxt = acc_r;
        else                top_nxt = neg_r ? alu_sum[DATA_WIDTH-1:0] : x_r;
        depth_nxt = depth_r - DEP_W'(1);
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_top_nxt   = (depth_r != '0) ? TOP_W'(top_r) : '0;
          out_depth_nxt = depth_r;
          out_err_nxt   = err_r;
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    err_r       <= err_nxt;
    top_r       <= top_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    acc_r       <= acc_nxt;
    neg_r       <= neg_nxt;
    cnt_r       <= cnt_nxt;
    out_top_r   <= out_top_nxt;
    out_depth_r <= out_depth_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_top_value   = out_top_r;
  assign out_stack_depth = out_depth_r;
  assign out_error_code  = out_err_r;

  // Checks
  `DSA_ASSERT(a_depth_bound, depth_r <= DEP_W'(STACK_DEPTH), "stack depth beyond capacity")
  `DSA_ASSERT_IMP(a_valid_from_resp, $rose(out_valid_r),
    $past(state_r) == S_RESP, "result without response state")
  `DSA_ASSERT_IMP(a_err_keeps_depth, (state_r == S_RESP) && (err_r != ERR_OK),
    depth_r == $past(depth_r), "failed item changed depth")
  `DSA_ASSERT_IMP(a_busy_no_result, (state_r != S_IDLE) && (state_r != S_RESP),
    out_valid_r == 1'b0 || $past(out_valid_r), "result appeared mid-item")

endmodule

`default_nettype wire
